// ----- hdl/bankers_pkg.sv -----
// Shared constants and types for the request safety check unit.
// No dependencies; used by every module under hdl.
package bankers_pkg;

  localparam int MaxProcesses = 16;
  localparam int MaxResources = 16;
  localparam int PW = $clog2(MaxProcesses);
  localparam int RW = $clog2(MaxResources);
  localparam int CntW = 5;
  localparam int AmtW = 16;
  localparam int WorkW = 20;
  localparam logic [WorkW-1:0] WorkMax = {WorkW{1'b1}};

  localparam logic [1:0] OpLoadAlloc = 2'd0;
  localparam logic [1:0] OpLoadMax   = 2'd1;
  localparam logic [1:0] OpLoadAvail = 2'd2;
  localparam logic [1:0] OpRequest   = 2'd3;

  localparam logic [2:0] StGranted = 3'd0;
  localparam logic [2:0] StExceeds = 3'd1;
  localparam logic [2:0] StWait    = 3'd2;
  localparam logic [2:0] StUnsafe  = 3'd3;
  localparam logic [2:0] StBadProc = 3'd4;

  localparam logic CfgProcs = 1'b0;
  localparam logic CfgRes   = 1'b1;

  // control sent from the sequencer to every cell of the chain
  typedef struct packed {
    logic          init;     // load work from available
    logic          shift;    // rotate the chain by one place
    logic          acc;      // add the shifted-in allocation into work
    logic          grant;    // apply request to available
    logic          rollback; // undo request on available
    logic          clr_req;  // clear request buffer
  } cell_ctl_t;

endpackage

// ----- hdl/bankers_cell.sv -----
// One resource cell of the chain: holds available, request and work for
// one column. Depends on bankers_pkg.
module bankers_cell (
  input  logic                            clk,
  input  logic                            rst_n,
  input  bankers_pkg::cell_ctl_t          ctl,
  input  logic                            active,
  input  logic                            avail_we,
  input  logic                            req_we,
  input  logic [bankers_pkg::AmtW-1:0]    wr_data,
  input  logic [bankers_pkg::AmtW-1:0]    alloc_in,
  // neighbour chain: values travel from cell i+1 to cell i
  input  logic [bankers_pkg::AmtW-1:0]    avail_nb,
  input  logic [bankers_pkg::AmtW-1:0]    req_nb,
  input  logic [bankers_pkg::WorkW-1:0]   work_nb,
  input  logic                            act_nb,
  output logic [bankers_pkg::AmtW-1:0]    avail_o,
  output logic [bankers_pkg::AmtW-1:0]    req_o,
  output logic [bankers_pkg::WorkW-1:0]   work_o,
  output logic                            act_o
);

  logic [bankers_pkg::AmtW-1:0]  avail_r, req_r;
  logic [bankers_pkg::WorkW-1:0] work_r;
  logic                          act_r;
  logic [bankers_pkg::WorkW:0]   sum;

  assign sum = {1'b0, work_r} + {{(bankers_pkg::WorkW-bankers_pkg::AmtW+1){1'b0}}, alloc_in};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_r  <= '0;
      work_r <= '0;
      act_r  <= 1'b0;
    end else if (ctl.shift) begin
      avail_r <= avail_nb;
      req_r   <= req_nb;
      work_r  <= work_nb;
      act_r   <= act_nb;
    end else begin
      if (avail_we) avail_r <= wr_data;
      if (ctl.grant && active) avail_r <= avail_r - req_r;
      if (ctl.rollback && active) avail_r <= avail_r + req_r;
      if (ctl.clr_req) req_r <= '0;
      else if (req_we) req_r <= wr_data;
      if (ctl.init) begin
        work_r <= active ? {{(bankers_pkg::WorkW-bankers_pkg::AmtW){1'b0}}, avail_r} : '0;
        act_r  <= active;
      end
    end
  end

  assign avail_o = avail_r;
  assign req_o   = req_r;
  // fold the allocation into work as the column leaves the head cell
  assign work_o  = (ctl.acc && act_r) ?
                   (sum[bankers_pkg::WorkW] ? bankers_pkg::WorkMax
                                            : sum[bankers_pkg::WorkW-1:0]) : work_r;
  assign act_o   = act_r;

endmodule

// ----- hdl/bankers_request_safety_check_unit.sv -----
// Banker's algorithm request checker built as a rotating chain of resource
// cells. Depends on bankers_pkg and bankers_cell.
//
// Usage: load allocation, max claim and available entries with beats on the
// in_ channel (no result). Request elements (operation 3) fill the request
// buffer; the element with in_last high starts a check and yields one beat
// on the out_ channel with status and the echoed process index.
// Configuration (cfg_index 0 processes, 1 resources) must be written only
// while idle; the block itself does not enforce this. Every pass rotates
// the chain through all 16 columns, with a table read and then a compare
// at the head cell for each column: the screen, the grant, each process
// visit in a safety sweep and the accumulate of a finishing process are
// passes, and up to P sweeps of P visits run, all through the single table
// read port that feeds the head cell. A bad process skips the passes and
// goes straight to the result. The tables are two 256-entry memories.
// Reset clears control, request buffer, work and counts (1 process,
// 1 resource); the tables and available stay undefined until loaded.
// A stalled receiver holds the result register; in_ready stays low until
// the result beat is taken.
module bankers_request_safety_check_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [3:0]  in_process_index,
  input  logic [3:0]  in_resource_index,
  input  logic [15:0] in_amount,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [3:0]  out_process_echo,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_data
);

  localparam int NR = bankers_pkg::MaxResources;
  localparam int NP = bankers_pkg::MaxProcesses;
  localparam int AW = bankers_pkg::AmtW;
  localparam int WW = bankers_pkg::WorkW;
  localparam int PW = bankers_pkg::PW;
  localparam int RW = bankers_pkg::RW;

  typedef enum logic [3:0] {
    S_IDLE, S_SCREEN_RD, S_SCREEN, S_GRANT, S_ALLOC_RD, S_ALLOC_WR,
    S_INIT, S_SW_RD, S_SW_CMP, S_ACC_RD, S_ACC, S_UNDO_RD, S_UNDO_WR,
    S_CLEAR, S_OUT
  } state_t;

  state_t state_r;
  logic [bankers_pkg::CntW-1:0] nproc_r, nres_r;
  logic [PW-1:0] proc_r, p_r;
  logic [RW:0]   r_r;
  logic [2:0]    status_r;
  logic          fits_r, progress_r, unsafe_r;
  logic [NP-1:0] fin_r;
  logic [PW:0]   done_r;

  logic [AW-1:0] alloc_mem [NP*NR];
  logic [AW-1:0] maxc_mem  [NP*NR];
  logic [AW-1:0] alloc_rd_r, maxc_rd_r;

  logic [PW:0] np_use;
  logic [RW:0] nr_use;
  assign np_use = (nproc_r > bankers_pkg::CntW'(NP)) ? (PW+1)'(NP) : nproc_r[PW:0];
  assign nr_use = (nres_r > bankers_pkg::CntW'(NR)) ? (RW+1)'(NR) : nres_r[RW:0];

  bankers_pkg::cell_ctl_t ctl;
  logic [AW-1:0] avail_q [NR];
  logic [AW-1:0] req_q   [NR];
  logic [WW-1:0] work_q  [NR];
  logic          act_q   [NR];

  logic accept;
  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  // head column index: the chain has rotated r_r places since alignment
  logic [RW-1:0] col;
  assign col = r_r[RW-1:0];
  logic col_used;
  assign col_used = r_r < nr_use;
  logic [PW+RW-1:0] rd_addr;
  logic [PW-1:0] row;
  assign row = (state_r == S_SW_RD || state_r == S_SW_CMP || state_r == S_ACC_RD ||
                state_r == S_ACC) ? p_r : proc_r;
  assign rd_addr = {row, col};

  always_comb begin
    ctl = '0;
    ctl.init     = (state_r == S_INIT);
    ctl.grant    = (state_r == S_GRANT) && (status_r == bankers_pkg::StGranted);
    // undo once, while the chain is aligned at the start of the undo pass
    ctl.rollback = (state_r == S_UNDO_RD) && unsafe_r && (r_r == '0);
    ctl.clr_req  = (state_r == S_CLEAR);
    ctl.acc      = (state_r == S_ACC);
    ctl.shift    = (state_r == S_SCREEN) || (state_r == S_ALLOC_WR) ||
                   (state_r == S_SW_CMP) || (state_r == S_ACC) ||
                   (state_r == S_UNDO_WR);
  end

  for (genvar i = 0; i < NR; i++) begin : g_cell
    localparam int NB = (i + 1) % NR;
    bankers_cell u_cell (
      .clk(clk), .rst_n(rst_n), .ctl(ctl),
      .active(RW'(i) < nr_use[RW-1:0] || nr_use[RW]),
      .avail_we(accept && in_operation == bankers_pkg::OpLoadAvail &&
                in_resource_index == RW'(i)),
      .req_we(accept && in_operation == bankers_pkg::OpRequest &&
              in_resource_index == RW'(i)),
      .wr_data(in_amount),
      .alloc_in((i == 0) ? alloc_rd_r : '0),
      .avail_nb(avail_q[NB]), .req_nb(req_q[NB]), .work_nb(work_q[NB]),
      .act_nb(act_q[NB]),
      .avail_o(avail_q[i]), .req_o(req_q[i]), .work_o(work_q[i]), .act_o(act_q[i])
    );
  end

  // table port
  logic          mem_we;
  logic [PW+RW-1:0] wr_addr;
  logic [AW-1:0] alloc_wd;
  always_comb begin
    mem_we   = 1'b0;
    wr_addr  = {in_process_index, in_resource_index};
    alloc_wd = in_amount;
    if (accept && in_operation == bankers_pkg::OpLoadAlloc) mem_we = 1'b1;
    if (state_r == S_ALLOC_WR || (state_r == S_UNDO_WR && unsafe_r)) begin
      mem_we  = col_used;
      wr_addr = {proc_r, col};
      alloc_wd = unsafe_r ? alloc_rd_r - req_q[0] : alloc_rd_r + req_q[0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) alloc_mem[wr_addr] <= alloc_wd;
    if (accept && in_operation == bankers_pkg::OpLoadMax)
      maxc_mem[{in_process_index, in_resource_index}] <= in_amount;
    alloc_rd_r <= alloc_mem[rd_addr];
    maxc_rd_r  <= maxc_mem[rd_addr];
  end

  // need and compare at the head cell
  logic signed [AW+1:0] need;
  logic last_proc, any_left;
  assign need = $signed({2'b0, maxc_rd_r}) - $signed({2'b0, alloc_rd_r});
  assign last_proc = ({1'b0, p_r} + 1'b1) >= np_use;
  assign any_left  = done_r < np_use;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      nproc_r  <= bankers_pkg::CntW'(1);
      nres_r   <= bankers_pkg::CntW'(1);
      out_valid <= 1'b0;
      fin_r    <= '0;
      unsafe_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == bankers_pkg::CfgProcs) nproc_r <= cfg_data;
        else nres_r <= cfg_data;
      end
      case (state_r)
        S_IDLE: begin
          if (accept && in_operation == bankers_pkg::OpRequest && in_last) begin
            proc_r   <= in_process_index;
            unsafe_r <= 1'b0;
            r_r      <= '0;
            if ({1'b0, in_process_index} >= np_use) begin
              status_r <= bankers_pkg::StBadProc;
              state_r  <= S_CLEAR;
            end else if (nr_use == '0) begin
              status_r <= bankers_pkg::StGranted;
              state_r  <= S_CLEAR;
            end else begin
              status_r <= bankers_pkg::StGranted;
              state_r  <= S_SCREEN_RD;
            end
          end
        end
        // screen pass: each column is read, then compared at the head cell
        S_SCREEN_RD: state_r <= S_SCREEN;
        S_SCREEN: begin
          if (status_r == bankers_pkg::StGranted && col_used) begin
            if ($signed({2'b0, req_q[0]}) > need) status_r <= bankers_pkg::StExceeds;
            else if (req_q[0] > avail_q[0]) status_r <= bankers_pkg::StWait;
          end
          if (r_r == (RW+1)'(NR-1)) begin
            r_r <= '0;
            state_r <= S_GRANT;
          end else begin
            r_r <= r_r + 1'b1;
            state_r <= S_SCREEN_RD;
          end
        end
        S_GRANT: begin
          // a full rotation has realigned the chain
          if (status_r != bankers_pkg::StGranted) state_r <= S_CLEAR;
          else state_r <= S_ALLOC_RD;
        end
        S_ALLOC_RD: state_r <= S_ALLOC_WR;
        S_ALLOC_WR: begin
          if (r_r == (RW+1)'(NR-1)) begin
            r_r <= '0;
            state_r <= S_INIT;
          end else begin
            r_r <= r_r + 1'b1;
            state_r <= S_ALLOC_RD;
          end
        end
        S_INIT: begin
          fin_r <= '0;
          done_r <= '0;
          p_r <= '0;
          progress_r <= 1'b0;
          fits_r <= 1'b1;
          state_r <= S_SW_RD;
        end
        S_SW_RD: state_r <= S_SW_CMP;
        S_SW_CMP: begin
          if (act_q[0] && need > $signed({2'b0, work_q[0]})) fits_r <= 1'b0;
          if (r_r == (RW+1)'(NR-1)) begin
            r_r <= '0;
            state_r <= S_ACC_RD;
          end else begin
            r_r <= r_r + 1'b1;
            state_r <= S_SW_RD;
          end
        end
        S_ACC_RD: begin
          if (fin_r[p_r] || !fits_r) begin
            // next process or end of sweep
            fits_r <= 1'b1;
            if (last_proc) begin
              p_r <= '0;
              if (!any_left) state_r <= S_UNDO_RD;
              else if (!progress_r) begin
                unsafe_r <= 1'b1;
                status_r <= bankers_pkg::StUnsafe;
                state_r  <= S_UNDO_RD;
              end else begin
                progress_r <= 1'b0;
                state_r <= S_SW_RD;
              end
            end else begin
              p_r <= p_r + 1'b1;
              state_r <= S_SW_RD;
            end
          end else state_r <= S_ACC;
        end
        S_ACC: begin
          if (r_r == (RW+1)'(NR-1)) begin
            r_r <= '0;
            fin_r[p_r] <= 1'b1;
            done_r <= done_r + 1'b1;
            progress_r <= 1'b1;
            fits_r <= 1'b0;
          end else r_r <= r_r + 1'b1;
          state_r <= S_ACC_RD;
        end
        S_UNDO_RD: begin
          if (!unsafe_r) state_r <= S_CLEAR;
          else state_r <= S_UNDO_WR;
        end
        S_UNDO_WR: begin
          if (r_r == (RW+1)'(NR-1)) begin
            r_r <= '0;
            unsafe_r <= 1'b0;
            state_r <= S_CLEAR;
          end else begin
            r_r <= r_r + 1'b1;
            state_r <= S_UNDO_RD;
          end
        end
        S_CLEAR: begin
          out_valid <= 1'b1;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_status       = status_r;
  assign out_process_echo = proc_r;

endmodule
